@@ hdl/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// swr_pkg
// Types and codes shared by the stop-and-wait receiver modules.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam logic [7:0] FLG_SYN      = 8'h01;
   localparam logic [7:0] FLG_ACK      = 8'h02;
   localparam logic [7:0] FLG_SYN_ACK  = 8'h03;
   localparam logic [7:0] FLG_FIN      = 8'h04;
   localparam logic [7:0] FLG_FIN_ACK  = 8'h06;
   localparam logic [7:0] FLG_FILE_END = 8'h07;

   localparam logic [1:0] ACT_DISCARD = 2'd0;
   localparam logic [1:0] ACT_NAME    = 2'd1;
   localparam logic [1:0] ACT_WRITE   = 2'd2;

   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_CONNECTED = 3'd1;
   localparam logic [2:0] ST_RELEASED  = 3'd2;
   localparam logic [2:0] ST_FAILED    = 3'd3;
   localparam logic [2:0] ST_FILE_DONE = 3'd4;

   localparam logic REG_RETRY_LIMIT     = 1'b0;
   localparam logic REG_WRONG_ACK_LIMIT = 1'b1;

   typedef struct packed {
      logic        timer;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] port;
      logic        ok;
   } swr_req_type;

   typedef struct packed {
      logic        send_packet;
      logic [7:0]  out_flags;
      logic [31:0] out_seq;
      logic [31:0] out_ack;
      logic [15:0] out_port;
      logic [1:0]  payload_action;
      logic [2:0]  status;
   } swr_rsp_type;

   typedef struct packed {
      logic [2:0] retry_limit;
      logic [2:0] wrong_ack_limit;
   } swr_cfg_type;

endpackage

@@ hdl/swr_engine.sv @@
// ----------------------------------------------------------------------------
// swr_engine
// Connection state and the per-word decision: one word in, at most one reply.
// ----------------------------------------------------------------------------
module swr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  swr_pkg::swr_req_type req_word,
   input  swr_pkg::swr_cfg_type cfg,
   output logic                 has_result,
   output swr_pkg::swr_rsp_type rsp_word
);
   import swr_pkg::*;

   typedef enum logic [1:0] {
      PH_LISTEN = 2'd0,
      PH_SHAKE  = 2'd1,
      PH_CONN   = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        closing_ff, closing_in;
   logic        name_ff, name_in;
   logic [31:0] own_seq_ff, own_seq_in;
   logic [31:0] last_ack_ff, last_ack_in;
   logic [31:0] expected_ff, expected_in;
   logic [2:0]  retry_ff, retry_in;
   logic [2:0]  wrong_ff, wrong_in;
   logic [15:0] peer_port_ff, peer_port_in;

   logic [31:0] seq_p1;
   logic [31:0] own_p1;
   logic [2:0]  retry_p1;
   logic [2:0]  wrong_p1;

   assign seq_p1   = req_word.seq + 32'd1;
   assign own_p1   = own_seq_ff + 32'd1;
   assign retry_p1 = retry_ff + 3'd1;
   assign wrong_p1 = wrong_ff + 3'd1;

   always_comb begin
      phase_in     = phase_ff;
      closing_in   = closing_ff;
      name_in      = name_ff;
      own_seq_in   = own_seq_ff;
      last_ack_in  = last_ack_ff;
      expected_in  = expected_ff;
      retry_in     = retry_ff;
      wrong_in     = wrong_ff;
      peer_port_in = peer_port_ff;
      has_result   = 1'b0;
      rsp_word     = '0;

      unique case (phase_ff)
         PH_SHAKE: begin
            if (req_word.timer) begin
               if (retry_p1 >= cfg.retry_limit) begin
                  phase_in        = PH_LISTEN;
                  closing_in      = 1'b0;
                  name_in         = 1'b0;
                  retry_in        = 3'd0;
                  wrong_in        = 3'd0;
                  has_result      = 1'b1;
                  rsp_word.status = ST_FAILED;
               end else begin
                  retry_in             = retry_p1;
                  wrong_in             = 3'd0;
                  has_result           = 1'b1;
                  rsp_word.send_packet = 1'b1;
                  rsp_word.out_flags   = closing_ff ? FLG_FIN_ACK : FLG_SYN_ACK;
                  rsp_word.out_seq     = own_seq_ff;
                  rsp_word.out_ack     = last_ack_ff;
                  rsp_word.out_port    = peer_port_ff;
               end
            end else if (req_word.flags == FLG_ACK && req_word.ack == own_p1) begin
               phase_in        = closing_ff ? PH_LISTEN : PH_CONN;
               closing_in      = 1'b0;
               retry_in        = 3'd0;
               wrong_in        = 3'd0;
               has_result      = 1'b1;
               rsp_word.status = closing_ff ? ST_RELEASED : ST_CONNECTED;
            end else if (wrong_p1 >= cfg.wrong_ack_limit) begin
               wrong_in             = 3'd0;
               has_result           = 1'b1;
               rsp_word.send_packet = 1'b1;
               rsp_word.out_flags   = closing_ff ? FLG_FIN_ACK : FLG_SYN_ACK;
               rsp_word.out_seq     = own_seq_ff;
               rsp_word.out_ack     = last_ack_ff;
               rsp_word.out_port    = peer_port_ff;
            end else begin
               wrong_in = wrong_p1;
            end
         end
         PH_CONN: begin
            if (!req_word.timer) begin
               has_result           = 1'b1;
               rsp_word.send_packet = 1'b1;
               rsp_word.out_flags   = FLG_ACK;
               rsp_word.out_seq     = own_p1;
               rsp_word.out_ack     = seq_p1;
               rsp_word.out_port    = req_word.port;
               own_seq_in           = own_p1;
               last_ack_in          = seq_p1;
               if (req_word.flags == FLG_FIN) begin
                  peer_port_in       = req_word.port;
                  phase_in           = PH_SHAKE;
                  closing_in         = 1'b1;
                  name_in            = 1'b0;
                  retry_in           = 3'd0;
                  wrong_in           = 3'd0;
                  rsp_word.out_flags = FLG_FIN_ACK;
               end else if (req_word.flags == FLG_FILE_END) begin
                  name_in         = 1'b0;
                  rsp_word.status = ST_FILE_DONE;
               end else if (!name_ff) begin
                  name_in                 = 1'b1;
                  rsp_word.payload_action = ACT_NAME;
                  if (req_word.ok) begin
                     expected_in = seq_p1;
                  end else begin
                     own_seq_in           = own_seq_ff;
                     last_ack_in          = last_ack_ff;
                     rsp_word.send_packet = 1'b0;
                     rsp_word.out_flags   = 8'd0;
                     rsp_word.out_seq     = 32'd0;
                     rsp_word.out_ack     = 32'd0;
                     rsp_word.out_port    = 16'd0;
                  end
               end else if (req_word.seq == expected_ff && req_word.ok) begin
                  expected_in             = seq_p1;
                  rsp_word.payload_action = ACT_WRITE;
               end else begin
                  last_ack_in             = expected_ff;
                  rsp_word.out_ack        = expected_ff;
                  rsp_word.payload_action = ACT_DISCARD;
               end
            end
         end
         default: begin
            if (!req_word.timer && req_word.flags == FLG_SYN) begin
               own_seq_in           = 32'd0;
               expected_in          = 32'd0;
               last_ack_in          = seq_p1;
               peer_port_in         = req_word.port;
               name_in              = 1'b0;
               closing_in           = 1'b0;
               retry_in             = 3'd0;
               wrong_in             = 3'd0;
               phase_in             = PH_SHAKE;
               has_result           = 1'b1;
               rsp_word.send_packet = 1'b1;
               rsp_word.out_flags   = FLG_SYN_ACK;
               rsp_word.out_seq     = 32'd0;
               rsp_word.out_ack     = seq_p1;
               rsp_word.out_port    = req_word.port;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LISTEN;
         closing_ff   <= 1'b0;
         name_ff      <= 1'b0;
         own_seq_ff   <= 32'd0;
         last_ack_ff  <= 32'd0;
         expected_ff  <= 32'd0;
         retry_ff     <= 3'd0;
         wrong_ff     <= 3'd0;
         peer_port_ff <= 16'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         closing_ff   <= closing_in;
         name_ff      <= name_in;
         own_seq_ff   <= own_seq_in;
         last_ack_ff  <= last_ack_in;
         expected_ff  <= expected_in;
         retry_ff     <= retry_in;
         wrong_ff     <= wrong_in;
         peer_port_ff <= peer_port_in;
      end
   end

endmodule

@@ hdl/stop_and_wait_receiver.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_receiver
// Receiver side of a stop-and-wait link: handshake, data acks, close.
// A reply is registered when its word leaves the input register. Throughput:
// one word per cycle unless the reply stalls; the decision is one pass through
// swr_engine between the input register and the reply register. Reset clears
// the connection state, the stage valids and sets both limits to 3. Words with
// no reply still take one slot through the input register.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_pkt_flags,
   input  logic [31:0] req_pkt_seq,
   input  logic [31:0] req_pkt_ack,
   input  logic [15:0] req_pkt_port,
   input  logic        req_checksum_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_packet,
   output logic [7:0]  rsp_out_flags,
   output logic [31:0] rsp_out_seq,
   output logic [31:0] rsp_out_ack,
   output logic [15:0] rsp_out_port,
   output logic [1:0]  rsp_payload_action,
   output logic [2:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import swr_pkg::*;

   swr_cfg_type cfg_ff;
   logic        in_valid_ff;
   swr_req_type in_word_ff;
   logic        out_valid_ff;
   swr_rsp_type out_word_ff;
   logic        advance;
   logic        has_result;
   swr_rsp_type rsp_word;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         REG_RETRY_LIMIT: csr_prdata = {29'd0, cfg_ff.retry_limit};
         default:         csr_prdata = {29'd0, cfg_ff.wrong_ack_limit};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit     <= 3'd3;
         cfg_ff.wrong_ack_limit <= 3'd3;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_RETRY_LIMIT) begin
            cfg_ff.retry_limit <= csr_pwdata[2:0];
         end else begin
            cfg_ff.wrong_ack_limit <= csr_pwdata[2:0];
         end
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff.timer <= req_type;
         in_word_ff.flags <= req_pkt_flags;
         in_word_ff.seq   <= req_pkt_seq;
         in_word_ff.ack   <= req_pkt_ack;
         in_word_ff.port  <= req_pkt_port;
         in_word_ff.ok    <= req_checksum_ok;
      end
   end

   swr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .req_word   (in_word_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .rsp_word   (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= has_result;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_word_ff <= rsp_word;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_send_packet    = out_word_ff.send_packet;
   assign rsp_out_flags      = out_word_ff.out_flags;
   assign rsp_out_seq        = out_word_ff.out_seq;
   assign rsp_out_ack        = out_word_ff.out_ack;
   assign rsp_out_port       = out_word_ff.out_port;
   assign rsp_payload_action = out_word_ff.payload_action;
   assign rsp_status         = out_word_ff.status;

   a_quiet_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_send_packet) |->
         (rsp_out_flags == 8'd0 && rsp_out_seq == 32'd0 &&
          rsp_out_ack == 32'd0 && rsp_out_port == 16'd0))
      else $error("reply fields set without a packet");

   a_reply_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_packet) |->
         (rsp_out_flags == FLG_ACK || rsp_out_flags == FLG_SYN_ACK ||
          rsp_out_flags == FLG_FIN_ACK))
      else $error("bad reply flags");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload_action != 2'd3))
      else $error("bad payload action");

   a_event_no_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_CONNECTED || rsp_status == ST_RELEASED ||
                     rsp_status == ST_FAILED)) |-> !rsp_send_packet)
      else $error("handshake event with a packet");

   a_hold_stalled_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("pending word dropped under stall");

endmodule
